// File: hdl/mbpf_pkg.sv
// Shared constants and types for the Morse bond force pipeline.
// No dependencies; imported by every other file of the block except mbpf_delay.
package mbpf_pkg;

  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int PARM_W  = 31;
  localparam int ROOT_W  = 31;
  localparam int SQ_W    = 2 * ROOT_W;
  localparam int P_W     = 2 * PARM_W - FRAC_W;
  localparam int MAG_W   = 62;
  localparam int UNIT_W  = 31;
  localparam int AXES    = 3;
  localparam int TERMS   = 7;

  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = UNIT_W;
  localparam int EXP_LAT  = 35;
  localparam int PIPE_LAT = 3 + SQRT_LAT + EXP_LAT + 2;

  localparam logic [MAG_W-1:0]  CAP         = '1;
  localparam logic [30:0]       LOG2E_Q30   = 31'd1549082005;
  localparam logic [29:0]       LN2_Q30     = 30'd744261118;
  localparam logic [30:0]       Q30_ONE     = 31'h4000_0000;
  localparam logic [MAG_W-1:0]  Q32_ONE     = 62'h1_0000_0000;
  localparam logic [PARM_W-1:0] BREAK_RESET = 31'd196608;

  typedef struct packed {
    logic       cap;
    logic       zero;
    logic       left;
    logic [5:0] amt;
  } exp_ctl_t;

  typedef struct packed {
    logic                             brk;
    logic [AXES-1:0]                  dneg;
    logic [AXES-1:0][PARM_W-1:0]      dm;
    logic [PARM_W-1:0]                st;
    logic [PARM_W-1:0]                r0;
    logic [P_W-1:0]                   p;
  } side_t;

  typedef struct packed {
    logic            brk;
    logic            rz;
    logic [AXES-1:0] dneg;
  } tag_t;

endpackage

// File: hdl/mbpf_if.sv
// Bond input and force output channels with valid/ready handshake.
// Depends on mbpf_pkg for field widths.
interface mbpf_bond_if import mbpf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  first_x;
  logic signed [VAL_W-1:0]  first_y;
  logic signed [VAL_W-1:0]  first_z;
  logic signed [VAL_W-1:0]  second_x;
  logic signed [VAL_W-1:0]  second_y;
  logic signed [VAL_W-1:0]  second_z;
  logic [PARM_W-1:0]        well_depth;
  logic [PARM_W-1:0]        stiffness;
  logic [PARM_W-1:0]        rest_length;
  logic                     indices_valid;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  well_depth, stiffness, rest_length, indices_valid, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                well_depth, stiffness, rest_length, indices_valid, output ready);
endinterface

interface mbpf_force_if import mbpf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  force_x;
  logic signed [VAL_W-1:0]  force_y;
  logic signed [VAL_W-1:0]  force_z;
  logic                     force_present;
  logic                     bond_broken;
  logic                     saturated;

  modport source (output valid, force_x, force_y, force_z, force_present, bond_broken,
                  saturated, input ready);
  modport sink (input valid, force_x, force_y, force_z, force_present, bond_broken,
                saturated, output ready);
endinterface

// File: hdl/mbpf_delay.sv
// Enabled shift line that keeps side data aligned with the compute stages.
// No dependencies.
module mbpf_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

// File: hdl/mbpf_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on mbpf_pkg.
module mbpf_sqrt import mbpf_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   sq_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [31:0]       rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SQ_W-1:0]   sq_q   [ROOT_W-1];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    localparam int Bit = ROOT_W - 1 - j;
    logic [31:0]       rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   sq_in;
    logic [33:0]       rem_sh;
    logic [33:0]       trial;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sq_in   = sq_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign sq_in   = sq_q[j-1];
    end

    assign rem_sh = {rem_in, sq_in[2*Bit+1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[j]  <= 32'(rem_sh - trial);
          root_q[j] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh[31:0];
          root_q[j] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end

    if (j < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sq_q[j] <= sq_in;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// File: hdl/mbpf_div.sv
// Pipelined restoring divider, three lanes sharing one divisor.
// Depends on mbpf_pkg. Quotient is (num << 30) / den with num <= den.
module mbpf_div import mbpf_pkg::*; (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [AXES-1:0][PARM_W-1:0] num_i,
  input  logic [ROOT_W-1:0]           den_i,
  output logic [AXES-1:0][UNIT_W-1:0] quo_o
);

  logic [ROOT_W-1:0] den_q [UNIT_W-1];
  logic [30:0]       rem_q [AXES][UNIT_W-1];
  logic [UNIT_W-1:0] quo_q [AXES][UNIT_W];

  for (genvar j = 0; j < UNIT_W - 1; j++) begin : g_den
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= (j == 0) ? den_i : den_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    for (genvar j = 0; j < UNIT_W; j++) begin : g_step
      logic [31:0]       rem2;
      logic [31:0]       den_ext;
      logic [UNIT_W-1:0] quo_in;
      logic              ge;

      if (j == 0) begin : g_first
        assign rem2    = {1'b0, num_i[a]};
        assign den_ext = {1'b0, den_i};
        assign quo_in  = '0;
      end else begin : g_next
        assign rem2    = {rem_q[a][j-1], 1'b0};
        assign den_ext = {1'b0, den_q[j-1]};
        assign quo_in  = quo_q[a][j-1];
      end

      assign ge = rem2 >= den_ext;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[a][j] <= {quo_in[UNIT_W-2:0], ge};
        end
      end

      if (j < UNIT_W - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[a][j] <= ge ? 31'(rem2 - den_ext) : rem2[30:0];
          end
        end
      end
    end
    assign quo_o[a] = quo_q[a][UNIT_W-1];
  end

endmodule

// File: hdl/mbpf_exp.sv
// Exponent chain: e = exp(-a(r - r0)), g = e(e - 1), mag = 2*De*a*g, saturating.
// Depends on mbpf_pkg and mbpf_delay. Pipelined in EXP_LAT stages.
module mbpf_exp import mbpf_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [PARM_W-1:0] rest_i,
  input  logic [PARM_W-1:0] stiff_i,
  input  logic [P_W-1:0]    prod_i,
  output logic [MAG_W-1:0]  mag_o,
  output logic              gneg_o
);

  logic [31:0]       u;
  logic [30:0]       umag1_q;
  logic              ypos1_q, ypos2_q, ypos3_q, ypos4_q;
  logic [PARM_W-1:0] st1_q;
  logic [61:0]       ayprod;
  logic [45:0]       ay2_q;
  logic [53:0]       tl3_q, th3_q;
  logic [76:0]       tfull;
  logic [46:0]       t4_q;
  logic [30:0]       ip;
  logic [15:0]       fr;
  logic [31:0]       kneg;
  exp_ctl_t          ctl5_d, ctl5_q, ctl6_q;
  logic [15:0]       frac5_d, frac5_q;
  logic [59:0]       zprod;
  logic [29:0]       z6_q;

  logic [30:0] xa_q [TERMS];
  logic [30:0] suma_q [TERMS];
  logic [29:0] za_q [TERMS];
  exp_ctl_t    ctla_q [TERMS];
  logic [30:0] xb_q [TERMS];
  logic [30:0] qb_q [TERMS];
  logic [30:0] sumb_q [TERMS];
  logic [29:0] zb_q [TERMS];
  exp_ctl_t    ctlb_q [TERMS];
  logic [30:0] termc_q [TERMS];
  logic [30:0] sumc_q [TERMS];
  logic [29:0] zc_q [TERMS];
  exp_ctl_t    ctlc_q [TERMS];

  logic [MAG_W-1:0] e_d, e28_q, ediff;
  logic [47:0]      e29_q, d29_q;
  logic             big29_q, gneg29_q, big30_q, gneg30_q, gneg31_q;
  logic [47:0]      a00_q, a01_q, a10_q, a11_q;
  logic [95:0]      gsum;
  logic [MAG_W-1:0] g31_q;
  logic [P_W-1:0]   p31;
  logic [53:0]      pp00_q, pp01_q, pp10_q, pp11_q;
  logic [84:0]      lo33_q, hi33_q;
  logic [107:0]     full;
  logic [75:0]      q34_q;
  logic [MAG_W-1:0] m1;
  logic [MAG_W-1:0] mag35_q;

  assign u      = {1'b0, root_i} - {1'b0, rest_i};
  assign ayprod = 62'(st1_q) * 62'(umag1_q);
  assign tfull  = 77'(tl3_q) + (77'(th3_q) << 23);
  assign ip     = t4_q[46:FRAC_W];
  assign fr     = t4_q[FRAC_W-1:0];
  assign kneg   = {1'b0, ip} + 32'(fr != '0);
  assign zprod  = 60'({frac5_q, {(30-FRAC_W){1'b0}}}) * 60'(LN2_Q30);

  always_comb begin
    ctl5_d  = '0;
    frac5_d = fr;
    if (ypos4_q) begin
      ctl5_d.left = 1'b1;
      ctl5_d.cap  = ip >= 31'd30;
      ctl5_d.amt  = ip[5:0] + 6'd2;
    end else begin
      frac5_d = -fr;
      if (kneg <= 32'd2) begin
        ctl5_d.left = 1'b1;
        ctl5_d.amt  = 6'(32'd2 - kneg);
      end else begin
        ctl5_d.zero = kneg >= 32'd65;
        ctl5_d.amt  = 6'(kneg - 32'd2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      umag1_q <= u[31] ? 31'(-u) : u[30:0];
      ypos1_q <= u[31];
      st1_q   <= stiff_i;
      ay2_q   <= ayprod[61:FRAC_W];
      ypos2_q <= ypos1_q;
      tl3_q   <= 54'(ay2_q[22:0]) * 54'(LOG2E_Q30);
      th3_q   <= 54'(ay2_q[45:23]) * 54'(LOG2E_Q30);
      ypos3_q <= ypos2_q;
      t4_q    <= tfull[76:30];
      ypos4_q <= ypos3_q;
      ctl5_q  <= ctl5_d;
      frac5_q <= frac5_d;
      z6_q    <= zprod[59:30];
      ctl6_q  <= ctl5_q;
    end
  end

  // Taylor series of 2^f, one term per three stages
  for (genvar k = 0; k < TERMS; k++) begin : g_term
    localparam int N = k + 1;
    localparam logic [32:0] Recip = 33'((64'd1 << 32) / N);
    logic [30:0] term_in, sum_in;
    logic [29:0] z_in;
    exp_ctl_t    ctl_in;
    logic [60:0] xprod;
    logic [63:0] qprod;
    logic [33:0] rmd;
    logic [30:0] term_d;

    if (k == 0) begin : g_first
      assign term_in = Q30_ONE;
      assign sum_in  = Q30_ONE;
      assign z_in    = z6_q;
      assign ctl_in  = ctl6_q;
    end else begin : g_next
      assign term_in = termc_q[k-1];
      assign sum_in  = sumc_q[k-1];
      assign z_in    = zc_q[k-1];
      assign ctl_in  = ctlc_q[k-1];
    end

    assign xprod  = 61'(term_in) * 61'(z_in);
    assign qprod  = 64'(xa_q[k]) * 64'(Recip);
    assign rmd    = 34'(xb_q[k]) - 34'(qb_q[k]) * 34'(N);
    assign term_d = qb_q[k] + 31'(rmd >= 34'(N));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xa_q[k]    <= xprod[60:30];
        suma_q[k]  <= sum_in;
        za_q[k]    <= z_in;
        ctla_q[k]  <= ctl_in;
        xb_q[k]    <= xa_q[k];
        qb_q[k]    <= qprod[62:32];
        sumb_q[k]  <= suma_q[k];
        zb_q[k]    <= za_q[k];
        ctlb_q[k]  <= ctla_q[k];
        termc_q[k] <= term_d;
        sumc_q[k]  <= sumb_q[k] + term_d;
        zc_q[k]    <= zb_q[k];
        ctlc_q[k]  <= ctlb_q[k];
      end
    end
  end

  always_comb begin
    if (ctlc_q[TERMS-1].cap) begin
      e_d = CAP;
    end else if (ctlc_q[TERMS-1].zero) begin
      e_d = '0;
    end else if (ctlc_q[TERMS-1].left) begin
      e_d = 62'(sumc_q[TERMS-1]) << ctlc_q[TERMS-1].amt;
    end else begin
      e_d = 62'(sumc_q[TERMS-1]) >> ctlc_q[TERMS-1].amt;
    end
  end

  assign ediff = (e28_q < Q32_ONE) ? Q32_ONE - e28_q : e28_q - Q32_ONE;
  assign gsum  = 96'(a00_q) + ((96'(a01_q) + 96'(a10_q)) << 24) + (96'(a11_q) << 48);
  assign full  = 108'(lo33_q) + (108'(hi33_q) << 23);
  assign m1    = (q34_q > 76'(CAP)) ? CAP : q34_q[61:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e28_q    <= e_d;
      e29_q    <= e28_q[47:0];
      d29_q    <= ediff[47:0];
      big29_q  <= |e28_q[61:48];
      gneg29_q <= e28_q < Q32_ONE;
      a00_q    <= 48'(e29_q[23:0]) * 48'(d29_q[23:0]);
      a01_q    <= 48'(e29_q[23:0]) * 48'(d29_q[47:24]);
      a10_q    <= 48'(e29_q[47:24]) * 48'(d29_q[23:0]);
      a11_q    <= 48'(e29_q[47:24]) * 48'(d29_q[47:24]);
      big30_q  <= big29_q;
      gneg30_q <= gneg29_q;
      g31_q    <= (big30_q || gsum[95:32] > 64'(CAP)) ? CAP : gsum[93:32];
      gneg31_q <= gneg30_q;
      pp00_q   <= 54'(p31[22:0]) * 54'(g31_q[30:0]);
      pp01_q   <= 54'(p31[22:0]) * 54'(g31_q[61:31]);
      pp10_q   <= 54'(p31[45:23]) * 54'(g31_q[30:0]);
      pp11_q   <= 54'(p31[45:23]) * 54'(g31_q[61:31]);
      lo33_q   <= 85'(pp00_q) + (85'(pp01_q) << 31);
      hi33_q   <= 85'(pp10_q) + (85'(pp11_q) << 31);
      q34_q    <= full[107:32];
      mag35_q  <= (m1 > (CAP >> 1)) ? CAP : {m1[60:0], 1'b0};
    end
  end

  mbpf_delay #(.WIDTH(P_W), .DEPTH(31)) u_p_dly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (prod_i),
    .q_o   (p31)
  );

  mbpf_delay #(.WIDTH(1), .DEPTH(4)) u_gneg_dly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (gneg31_q),
    .q_o   (gneg_o)
  );

  assign mag_o = mag35_q;

endmodule

// File: hdl/morse_bond_pair_force.sv
// Morse bond force pipeline: one bond per cycle in unless stalled, one force beat out per bond.
// Depends on mbpf_pkg, mbpf_if, mbpf_delay, mbpf_sqrt, mbpf_div and mbpf_exp.
//
// Accepts one bond beat every cycle unless stalled and returns its force beat in
// order. The path runs through the 31-stage square root followed by the 35-stage
// exponent chain (the 31-stage divider runs beside it), plus three front stages,
// two final multiply stages and the output register. The whole pipeline holds
// while the output register is full and not taken. break_distance is written
// through cfg_we_i/cfg_data_i and resets to 3.0.
module morse_bond_pair_force import mbpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PARM_W-1:0] cfg_data_i,
  mbpf_bond_if.sink         bond_i,
  mbpf_force_if.source      force_o
);

  localparam logic [MAG_W-1:0] POS_LIM = 62'((64'd1 << (VAL_W-1)) - 64'd1);
  localparam logic [MAG_W-1:0] NEG_LIM = 62'(64'd1 << (VAL_W-1));

  logic                 en;
  logic [PARM_W-1:0]    bd_q;
  logic [PIPE_LAT-1:0]  vld_q;
  logic                 out_valid_q;

  logic signed [VAL_W-1:0] pa [AXES];
  logic signed [VAL_W-1:0] pb [AXES];
  logic signed [VAL_W:0]   d  [AXES];
  logic [VAL_W:0]          dmag [AXES];
  logic                    far;

  logic [PARM_W-1:0] dm1_q [AXES];
  logic [AXES-1:0]   dneg1_q, dneg2_q;
  logic              brk1_q, brk2_q;
  logic [PARM_W-1:0] de1_q, st1_q, r01_q, st2_q, r02_q;
  logic [PARM_W-1:0] dm2_q [AXES];
  logic [61:0]       sq2_q [AXES];
  logic [61:0]       bd2_q, pf2_q;
  logic [63:0]       ssum;
  side_t             side3_q, side_a;
  logic [SQ_W-1:0]   s3_q;

  logic [ROOT_W-1:0]            root;
  logic [AXES-1:0][UNIT_W-1:0]  unit_raw, unit;
  logic [MAG_W-1:0]             mag;
  logic                         gneg, gneg_f;
  tag_t                         tag_in, tag_f;

  logic [61:0]  plo1_q [AXES];
  logic [61:0]  phi1_q [AXES];
  logic [92:0]  cfull [AXES];
  logic [MAG_W-1:0] c2_q [AXES];

  logic [VAL_W-1:0] fval [AXES];
  logic             sat_d;
  logic [VAL_W-1:0] fx_q, fy_q, fz_q;
  logic             present_q, broken_q, sat_q;

  assign en           = !out_valid_q || force_o.ready;
  assign bond_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bd_q <= BREAK_RESET;
    end else if (cfg_we_i) begin
      bd_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[PIPE_LAT-2:0], bond_i.valid};
      out_valid_q <= vld_q[PIPE_LAT-1];
    end
  end

  assign pa[0] = bond_i.first_x;
  assign pa[1] = bond_i.first_y;
  assign pa[2] = bond_i.first_z;
  assign pb[0] = bond_i.second_x;
  assign pb[1] = bond_i.second_y;
  assign pb[2] = bond_i.second_z;

  always_comb begin
    far = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      d[a]    = (VAL_W+1)'(pa[a]) - (VAL_W+1)'(pb[a]);
      dmag[a] = d[a][VAL_W] ? (VAL_W+1)'(-d[a]) : (VAL_W+1)'(d[a]);
      far     = far | (|dmag[a][VAL_W:PARM_W]);
    end
  end

  assign ssum = 64'(sq2_q[0]) + 64'(sq2_q[1]) + 64'(sq2_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        dm1_q[a]      <= dmag[a][PARM_W-1:0];
        dneg1_q[a]    <= d[a][VAL_W];
        sq2_q[a]      <= 62'(dm1_q[a]) * 62'(dm1_q[a]);
        dm2_q[a]      <= dm1_q[a];
        side3_q.dm[a] <= dm2_q[a];
      end
      brk1_q       <= far || !bond_i.indices_valid;
      de1_q        <= bond_i.well_depth;
      st1_q        <= bond_i.stiffness;
      r01_q        <= bond_i.rest_length;
      bd2_q        <= 62'(bd_q) * 62'(bd_q);
      pf2_q        <= 62'(de1_q) * 62'(st1_q);
      brk2_q       <= brk1_q;
      dneg2_q      <= dneg1_q;
      st2_q        <= st1_q;
      r02_q        <= r01_q;
      side3_q.brk  <= brk2_q || (ssum > 64'(bd2_q));
      side3_q.dneg <= dneg2_q;
      side3_q.st   <= st2_q;
      side3_q.r0   <= r02_q;
      side3_q.p    <= pf2_q[61:FRAC_W];
      s3_q         <= ssum[SQ_W-1:0];
    end
  end

  mbpf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   (s3_q),
    .root_o (root)
  );

  mbpf_delay #(.WIDTH($bits(side_t)), .DEPTH(SQRT_LAT)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side3_q),
    .q_o   (side_a)
  );

  mbpf_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (side_a.dm),
    .den_i (root),
    .quo_o (unit_raw)
  );

  mbpf_delay #(.WIDTH(AXES*UNIT_W), .DEPTH(EXP_LAT-DIV_LAT)) u_unit_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (unit_raw),
    .q_o   (unit)
  );

  mbpf_exp u_exp (
    .clk_i   (clk_i),
    .en_i    (en),
    .root_i  (root),
    .rest_i  (side_a.r0),
    .stiff_i (side_a.st),
    .prod_i  (side_a.p),
    .mag_o   (mag),
    .gneg_o  (gneg)
  );

  assign tag_in.brk  = side_a.brk;
  assign tag_in.rz   = root == '0;
  assign tag_in.dneg = side_a.dneg;

  mbpf_delay #(.WIDTH($bits(tag_t)), .DEPTH(EXP_LAT+2)) u_tag_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (tag_in),
    .q_o   (tag_f)
  );

  mbpf_delay #(.WIDTH(1), .DEPTH(2)) u_gneg_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (gneg),
    .q_o   (gneg_f)
  );

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      cfull[a] = 93'(plo1_q[a]) + (93'(phi1_q[a]) << 31);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        plo1_q[a] <= 62'(mag[30:0]) * 62'(unit[a]);
        phi1_q[a] <= 62'(mag[61:31]) * 62'(unit[a]);
        c2_q[a]   <= (cfull[a][92:30] > 63'(CAP)) ? CAP : cfull[a][91:30];
      end
    end
  end

  // clip and sign each component
  always_comb begin
    sat_d = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (c2_q[a] == '0) begin
        fval[a] = '0;
      end else if (gneg_f ^ tag_f.dneg[a]) begin
        if (c2_q[a] > NEG_LIM) begin
          fval[a] = NEG_LIM[VAL_W-1:0];
          sat_d   = 1'b1;
        end else begin
          fval[a] = VAL_W'(-c2_q[a]);
        end
      end else begin
        if (c2_q[a] > POS_LIM) begin
          fval[a] = POS_LIM[VAL_W-1:0];
          sat_d   = 1'b1;
        end else begin
          fval[a] = c2_q[a][VAL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tag_f.brk || tag_f.rz) begin
        fx_q      <= '0;
        fy_q      <= '0;
        fz_q      <= '0;
        present_q <= 1'b0;
        broken_q  <= tag_f.brk;
        sat_q     <= 1'b0;
      end else begin
        fx_q      <= fval[0];
        fy_q      <= fval[1];
        fz_q      <= fval[2];
        present_q <= 1'b1;
        broken_q  <= 1'b0;
        sat_q     <= sat_d;
      end
    end
  end

  assign force_o.valid         = out_valid_q;
  assign force_o.force_x       = fx_q;
  assign force_o.force_y       = fy_q;
  assign force_o.force_z       = fz_q;
  assign force_o.force_present = present_q;
  assign force_o.bond_broken   = broken_q;
  assign force_o.saturated     = sat_q;

  a_present_xor_broken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid |-> !(force_o.force_present && force_o.bond_broken))
    else $error("force beat both present and broken");

  a_sat_needs_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid && force_o.saturated |-> force_o.force_present)
    else $error("saturation flagged without a force");

  a_no_force_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid && !force_o.force_present |->
      force_o.force_x == '0 && force_o.force_y == '0 && force_o.force_z == '0)
    else $error("nonzero force on a beat without force");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(out_valid_q))
    else $error("pipeline moved during a stall");

endmodule
